// ===== design/scc_pkg.sv =====
// Shared types, constants and register codes for the Sankoff column combiner.
package scc_pkg;

  localparam int MaxLetters        = 4;
  localparam int DefaultNumLetters = 4;
  localparam int DefaultQueueDepth = 4;
  localparam int ScoreW            = 24;
  localparam int TermW             = ScoreW + 1;
  localparam int WeightW           = 16;
  localparam int TotalW            = 40;
  localparam int CostW             = 8;
  localparam int CfgDataW          = 32;
  localparam int CfgIndexW         = 2;

  localparam logic [ScoreW-1:0] ScoreMax = {ScoreW{1'b1}};
  localparam logic [TotalW-1:0] TotalMax = {TotalW{1'b1}};

  localparam logic [CfgDataW-1:0] CostRowReset [MaxLetters] = '{
    32'h0101_0100, 32'h0101_0001, 32'h0100_0101, 32'h0001_0101
  };

  typedef enum logic [CfgIndexW-1:0] {
    REG_COST_ROW_ZERO  = 2'd0,
    REG_COST_ROW_ONE   = 2'd1,
    REG_COST_ROW_TWO   = 2'd2,
    REG_COST_ROW_THREE = 2'd3
  } cfg_reg_t;

  typedef logic [ScoreW-1:0] score_t;
  typedef logic [TermW-1:0]  term_t;

  typedef struct packed {
    score_t               child_score_a;
    score_t               child_score_b;
    score_t               child_score_c;
    score_t               child_score_d;
    logic                 child_present;
    logic                 column_end;
    logic [WeightW-1:0]   column_weight;
    logic                 total_restart;
  } in_item_t;

  typedef struct packed {
    score_t               node_score_a;
    score_t               node_score_b;
    score_t               node_score_c;
    score_t               node_score_d;
    score_t               column_minimum;
    logic                 column_occupied;
    logic [TotalW-1:0]    weighted_total;
  } out_item_t;

  // One classified item between front and back.
  typedef struct packed {
    term_t [MaxLetters-1:0] terms;
    logic                   present;
    logic                   col_end;
    logic [WeightW-1:0]     weight;
    logic                   restart;
  } q_entry_t;

  // Queue status seen by the two sides.
  typedef struct packed {
    logic full;
    logic nonempty;
  } q_status_t;

  function automatic score_t child_score(input in_item_t item, input int idx);
    score_t s;
    case (idx)
      0:       s = item.child_score_a;
      1:       s = item.child_score_b;
      2:       s = item.child_score_c;
      default: s = item.child_score_d;
    endcase
    return s;
  endfunction

endpackage

// ===== design/scc_front.sv =====
// Front end: input register, cost-matrix registers and min-plus term compute.
module scc_front #(
  parameter int NUM_LETTERS = scc_pkg::DefaultNumLetters
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  scc_pkg::in_item_t               in_item,
  input  logic                            wr_en,
  input  logic [scc_pkg::CfgIndexW-1:0]   wr_index,
  input  logic [scc_pkg::CfgDataW-1:0]    wr_data,
  input  scc_pkg::q_status_t              q_status,
  output logic                            push,
  output scc_pkg::q_entry_t               push_entry
);
  import scc_pkg::*;

  logic [CfgDataW-1:0] cost_rows [MaxLetters];
  in_item_t            f_item;
  logic                f_v;
  logic                f_ready;

  // cost matrix registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < MaxLetters; r++) cost_rows[r] <= CostRowReset[r];
    end else if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_COST_ROW_ZERO:  cost_rows[0] <= wr_data;
        REG_COST_ROW_ONE:   cost_rows[1] <= wr_data;
        REG_COST_ROW_TWO:   cost_rows[2] <= wr_data;
        REG_COST_ROW_THREE: cost_rows[3] <= wr_data;
        default: ;
      endcase
    end
  end

  assign f_ready  = !f_v || !q_status.full;
  assign in_stall = !f_ready;
  assign push     = f_v && !q_status.full;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_v <= 1'b0;
    end else if (f_ready) begin
      f_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (f_ready && in_valid) begin
      f_item <= in_item;
    end
  end

  // min over child letters of cost(p,c) + child score
  always_comb begin
    term_t best;
    term_t cand;
    push_entry = '0;
    for (int p = 0; p < MaxLetters; p++) begin
      best = '0;
      if (p < NUM_LETTERS) begin
        best = term_t'(cost_rows[p][0 +: CostW]) + term_t'(child_score(f_item, 0));
        for (int c = 1; c < NUM_LETTERS; c++) begin
          cand = term_t'(cost_rows[p][c*CostW +: CostW]) + term_t'(child_score(f_item, c));
          if (cand < best) best = cand;
        end
      end
      push_entry.terms[p] = best;
    end
    push_entry.present = f_item.child_present;
    push_entry.col_end = f_item.column_end;
    push_entry.weight  = f_item.column_weight;
    push_entry.restart = f_item.total_restart;
  end

endmodule

// ===== design/scc_queue.sv =====
// Small FIFO of classified items between front and back.
module scc_queue #(
  parameter int DEPTH = scc_pkg::DefaultQueueDepth
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  scc_pkg::q_entry_t   push_entry,
  input  logic                pop,
  output scc_pkg::q_entry_t   head,
  output scc_pkg::q_status_t  q_status
);
  import scc_pkg::*;

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  q_entry_t         slots [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;

  assign q_status.full     = (count == FullCnt);
  assign q_status.nonempty = (count != '0);
  assign head              = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= FullCnt)
    else $error("queue count above depth");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> count != '0)
    else $error("pop from empty queue");
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
      (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("push lost");

endmodule

// ===== design/scc_back.sv =====
// Back end: per-letter accumulator, column minimum, weight multiply, running total.
module scc_back #(
  parameter int NUM_LETTERS = scc_pkg::DefaultNumLetters
) (
  input  logic                clk,
  input  logic                rst,
  input  scc_pkg::q_entry_t   head,
  input  scc_pkg::q_status_t  q_status,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output scc_pkg::out_item_t  out_item
);
  import scc_pkg::*;

  typedef struct packed {
    score_t [MaxLetters-1:0] vec;
    logic                    occ;
    logic [WeightW-1:0]      weight;
    logic                    restart;
  } col_t;

  typedef struct packed {
    score_t [MaxLetters-1:0] vec;
    score_t                  min;
    logic                    occ;
    logic [TotalW-1:0]       prod;
    logic                    restart;
  } prod_t;

  score_t [MaxLetters-1:0] acc;
  logic                    occ;
  logic                    rst_pend;
  logic [TotalW-1:0]       total;

  col_t   a_q, a_next;
  col_t   b_q;
  score_t b_min, min_next;
  prod_t  c_q;
  logic   a_v, b_v, c_v;
  logic   a_ready, b_ready, c_ready, d_ready;

  logic [TotalW-1:0] total_base;
  logic [TotalW:0]   total_sum;
  logic [TotalW-1:0] total_next;

  assign d_ready = !out_valid || !out_stall;
  assign c_ready = !c_v || d_ready;
  assign b_ready = !b_v || c_ready;
  assign a_ready = !a_v || b_ready;
  assign pop     = q_status.nonempty && a_ready;

  // saturating accumulate of the head item
  always_comb begin
    logic [ScoreW+1:0] s;
    a_next = '0;
    for (int p = 0; p < MaxLetters; p++) begin
      s = {2'b00, acc[p]} + {1'b0, (head.present ? head.terms[p] : term_t'(0))};
      if (p < NUM_LETTERS) a_next.vec[p] = (s > (ScoreW+2)'(ScoreMax)) ? ScoreMax : s[ScoreW-1:0];
    end
    a_next.occ     = occ | head.present;
    a_next.weight  = head.weight;
    a_next.restart = rst_pend | head.restart;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      occ      <= 1'b0;
      rst_pend <= 1'b0;
    end else if (pop) begin
      if (head.col_end) begin
        acc      <= '0;
        occ      <= 1'b0;
        rst_pend <= 1'b0;
      end else begin
        acc      <= a_next.vec;
        occ      <= a_next.occ;
        rst_pend <= a_next.restart;
      end
    end
  end

  always_comb begin
    min_next = a_q.vec[0];
    for (int p = 1; p < NUM_LETTERS; p++) begin
      if (a_q.vec[p] < min_next) min_next = a_q.vec[p];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v       <= 1'b0;
      b_v       <= 1'b0;
      c_v       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (a_ready) a_v       <= pop && head.col_end;
      if (b_ready) b_v       <= a_v;
      if (c_ready) c_v       <= b_v;
      if (d_ready) out_valid <= c_v;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.col_end) a_q <= a_next;
    if (b_ready && a_v) begin
      b_q   <= a_q;
      b_min <= min_next;
    end
    if (c_ready && b_v) begin
      c_q.vec     <= b_q.vec;
      c_q.min     <= b_min;
      c_q.occ     <= b_q.occ;
      c_q.restart <= b_q.restart;
      c_q.prod    <= TotalW'(b_q.weight) * TotalW'(b_min);
    end
  end

  assign total_base = c_q.restart ? '0 : total;
  assign total_sum  = {1'b0, total_base} + {1'b0, c_q.prod};
  assign total_next = total_sum[TotalW] ? TotalMax : total_sum[TotalW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (c_v && d_ready) begin
      total <= total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (c_v && d_ready) begin
      out_item.node_score_a    <= c_q.vec[0];
      out_item.node_score_b    <= c_q.vec[1];
      out_item.node_score_c    <= c_q.vec[2];
      out_item.node_score_d    <= c_q.vec[3];
      out_item.column_minimum  <= c_q.min;
      out_item.column_occupied <= c_q.occ;
      out_item.weighted_total  <= total_next;
    end
  end

  a_empty_col_zero: assert property (@(posedge clk) disable iff (rst)
      (c_v && !c_q.occ) |-> (c_q.min == '0 && c_q.prod == '0))
    else $error("empty column carries a nonzero minimum");
  a_total_grows: assert property (@(posedge clk) disable iff (rst)
      (c_v && d_ready && !c_q.restart) |=> total >= $past(total))
    else $error("running total fell without restart");
  a_acc_cleared: assert property (@(posedge clk) disable iff (rst)
      (pop && head.col_end) |=> (acc == '0 && !occ && !rst_pend))
    else $error("accumulator not cleared at column end");

endmodule

// ===== design/sankoff_column_combine_top.sv =====
// Top level of the Sankoff weighted-parsimony column combiner.
//
//  channel  | handshake           | payload             | direction
//  ---------+---------------------+---------------------+----------
//  input    | in_valid / in_stall | in_item (in_item_t) | in
//  result   | out_valid/out_stall | out_item(out_item_t)| out
//  config   | wr_en               | wr_index, wr_data   | in
//
// One request per clock is taken in steady state while the queue is not full. The
// input register loads at the accepting edge; a column-end request then passes
// the queue write, accumulate, minimum, multiply and total add registers before
// out_valid rises. The accumulator add is the only loop on the per-request path.
// rst (synchronous, active high) clears the pipeline, queue, accumulator,
// running total and loads the default cost rows.
// in_stall rises only when the front register holds a request and the queue is
// full; out_stall backs up through the back stages into the queue.
module sankoff_column_combine_top #(
  parameter int NUM_LETTERS = scc_pkg::DefaultNumLetters,
  parameter int QUEUE_DEPTH = scc_pkg::DefaultQueueDepth
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  scc_pkg::in_item_t               in_item,
  output logic                            out_valid,
  input  logic                            out_stall,
  output scc_pkg::out_item_t              out_item,
  input  logic                            wr_en,
  input  logic [scc_pkg::CfgIndexW-1:0]   wr_index,
  input  logic [scc_pkg::CfgDataW-1:0]    wr_data
);
  import scc_pkg::*;

  q_status_t q_status;
  q_entry_t  push_entry;
  q_entry_t  head;
  logic      push;
  logic      pop;

  // front: input register plus min-plus terms for every parent letter
  scc_front #(.NUM_LETTERS(NUM_LETTERS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  // decouples term compute from the accumulate/total pipeline
  scc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .q_status   (q_status)
  );

  // back: accumulate per column, then min, weight multiply, saturating total
  scc_back #(.NUM_LETTERS(NUM_LETTERS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// ===== tb/sv/sankoff_column_combine_top_tb.sv =====
// Self-checking testbench for the Sankoff column combiner: predictor plus result scoreboard.
module sankoff_column_combine_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import scc_pkg::*;

  localparam int NumLetters   = DefaultNumLetters;
  // Pipeline stages plus a four-deep queue; leave plenty of margin.
  localparam int DrainCycles  = 24;
  localparam int RandomItems  = 550;
  localparam int RandomPhases = 4;
  localparam int DrainLimit   = 5000;

  localparam cfg_reg_t CostRowRegs [MaxLetters] = '{
    REG_COST_ROW_ZERO, REG_COST_ROW_ONE, REG_COST_ROW_TWO, REG_COST_ROW_THREE
  };

  typedef logic [MaxLetters-1:0][CfgDataW-1:0] cost_rows_t;

  // ---------------------------------------------------------------------------
  // Clock, reset and block inputs; every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_item_t            in_item   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_item_t           out_item;
  logic                wr_en     = 1'b0;
  logic [CfgIndexW-1:0] wr_index = '0;
  logic [CfgDataW-1:0] wr_data   = '0;

  always #5 clk = ~clk;

  sankoff_column_combine_top #(
    .NUM_LETTERS(NumLetters)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: cost matrix copy, per-letter parent costs of the open
  // column, occupancy of the open column and the weighted running total.
  // ---------------------------------------------------------------------------
  logic [CfgDataW-1:0] cost_row [MaxLetters];
  score_t              parent_cost [MaxLetters];
  logic                column_seen;
  logic [TotalW-1:0]   running_total;

  // Column results still owed by the block, oldest first.
  out_item_t           pending_columns [$];

  int unsigned         fail_count     = 0;
  logic                sender_gaps_on = 1'b1;

  // Receiver stall pattern state.
  int                  stall_left = 0;
  int                  free_left  = 0;

  function automatic logic [CostW-1:0] letter_cost(input int parent, input int child);
    return cost_row[parent][child*CostW +: CostW];
  endfunction

  task automatic reset_predictor();
    for (int p = 0; p < MaxLetters; p++) begin
      cost_row[p]    = CostRowReset[p];
      parent_cost[p] = '0;
    end
    column_seen   = 1'b0;
    running_total = '0;
  endtask

  // Fold one accepted request into the open column; on column end, close the
  // column and queue the result it must produce.
  task automatic predict_request(input in_item_t item);
    score_t              kid [MaxLetters];
    score_t              shown [MaxLetters];
    logic [ScoreW+1:0]   best;
    logic [ScoreW+1:0]   term;
    logic [ScoreW+1:0]   sum;
    score_t              low;
    logic [TotalW+1:0]   total;
    out_item_t           res;
    kid[0] = item.child_score_a;
    kid[1] = item.child_score_b;
    kid[2] = item.child_score_c;
    kid[3] = item.child_score_d;

    // Restart clears the total before anything this request adds.
    if (item.total_restart)
      running_total = '0;

    // Absent child contributes nothing, but its column end still counts.
    if (item.child_present) begin
      column_seen = 1'b1;
      for (int p = 0; p < NumLetters; p++) begin
        best = (ScoreW+2)'(letter_cost(p, 0)) + (ScoreW+2)'(kid[0]);
        for (int c = 1; c < NumLetters; c++) begin
          term = (ScoreW+2)'(letter_cost(p, c)) + (ScoreW+2)'(kid[c]);
          if (term < best)
            best = term;
        end
        sum = (ScoreW+2)'(parent_cost[p]) + best;
        parent_cost[p] = (sum > (ScoreW+2)'(ScoreMax)) ? ScoreMax : sum[ScoreW-1:0];
      end
    end

    if (!item.column_end)
      return;

    low = parent_cost[0];
    for (int p = 1; p < NumLetters; p++)
      if (parent_cost[p] < low)
        low = parent_cost[p];

    // Zero weight adds nothing; the total sticks at its maximum.
    total = (TotalW+2)'(running_total)
          + (TotalW+2)'(item.column_weight) * (TotalW+2)'(low);
    running_total = (total > (TotalW+2)'(TotalMax)) ? TotalMax : total[TotalW-1:0];

    // Letters beyond the configured count read as zero.
    for (int p = 0; p < MaxLetters; p++)
      shown[p] = (p < NumLetters) ? parent_cost[p] : '0;

    res.node_score_a    = shown[0];
    res.node_score_b    = shown[1];
    res.node_score_c    = shown[2];
    res.node_score_d    = shown[3];
    res.column_minimum  = low;
    res.column_occupied = column_seen;
    res.weighted_total  = running_total;
    pending_columns.push_back(res);

    for (int p = 0; p < MaxLetters; p++)
      parent_cost[p] = '0;
    column_seen = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("%0t ERROR: %s", $time, msg);
  endtask

  task automatic compare_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (pending_columns.size() == 0) begin
      report_mismatch($sformatf("result with no column pending, total %0h",
                                got.weighted_total));
      return;
    end
    want = pending_columns.pop_front();
    compare_field("node_score_a",    64'(got.node_score_a),    64'(want.node_score_a));
    compare_field("node_score_b",    64'(got.node_score_b),    64'(want.node_score_b));
    compare_field("node_score_c",    64'(got.node_score_c),    64'(want.node_score_c));
    compare_field("node_score_d",    64'(got.node_score_d),    64'(want.node_score_d));
    compare_field("column_minimum",  64'(got.column_minimum),  64'(want.column_minimum));
    compare_field("column_occupied", 64'(got.column_occupied), 64'(want.column_occupied));
    compare_field("weighted_total",  64'(got.weighted_total),  64'(want.weighted_total));
  endtask

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55)
      return 0;
    if (roll < 85)
      return $urandom_range(3, 1);
    if (roll < 97)
      return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Result side: sample the handshake with pre-edge values, then pick the next
  // stall level. Free runs are occasionally long so that stretches see no stall.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      check_result(out_item);
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (free_left > 0) begin
      free_left--;
      out_stall <= 1'b0;
    end else begin
      free_left  = ($urandom_range(9) == 0) ? $urandom_range(150, 40) : $urandom_range(6);
      stall_left = pick_gap();
      out_stall <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Valid is left high after acceptance so back-to-back requests never lower
  // and raise it within one step; the next gap or the idle wait lowers it.
  task automatic send_request(input in_item_t item);
    int gap;
    gap = sender_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    do begin
      @(posedge clk);
    end while (in_stall);
    predict_request(item);
  endtask

  function automatic in_item_t make_item(input score_t a, input score_t b, input score_t c,
                                         input score_t d, input logic present,
                                         input logic col_end,
                                         input logic [WeightW-1:0] weight,
                                         input logic restart);
    in_item_t item;
    item.child_score_a = a;
    item.child_score_b = b;
    item.child_score_c = c;
    item.child_score_d = d;
    item.child_present = present;
    item.column_end    = col_end;
    item.column_weight = weight;
    item.total_restart = restart;
    return item;
  endfunction

  // Sender holds off until every owed result is out, then lets the pipeline
  // settle: covers requests without a result still in flight.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_columns.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Writes all four cost rows, one per clock. Call only when idle.
  task automatic write_cost_rows(input cost_rows_t rows);
    for (int r = 0; r < MaxLetters; r++) begin
      wr_en    <= 1'b1;
      wr_index <= CostRowRegs[r];
      wr_data  <= rows[r];
      @(posedge clk);
      cost_row[CostRowRegs[r]] = rows[r];
    end
    wr_en <= 1'b0;
  endtask

  // style 0: tiny costs, 1: zero diagonal with random off-diagonal, else random
  function automatic cost_rows_t random_cost_rows(input int style);
    cost_rows_t rows;
    for (int p = 0; p < MaxLetters; p++)
      for (int c = 0; c < MaxLetters; c++)
        case (style)
          0:       rows[p][c*CostW +: CostW] = CostW'($urandom_range(3));
          1:       rows[p][c*CostW +: CostW] = (p == c) ? '0 : CostW'($urandom_range(255));
          default: rows[p][c*CostW +: CostW] = CostW'($urandom());
        endcase
    return rows;
  endfunction

  // Small values dominate so minima and totals stay readable; some columns
  // go wide or sit at the top to reach saturation.
  function automatic score_t random_score(input int mode);
    if (mode < 55)
      return score_t'($urandom_range(255));
    if (mode < 85)
      return score_t'($urandom_range(65535));
    if (mode < 95)
      return score_t'($urandom());
    return ScoreMax - score_t'($urandom_range(3));
  endfunction

  function automatic logic [WeightW-1:0] random_weight();
    int roll;
    roll = $urandom_range(99);
    if (roll < 2)
      return '0;
    if (roll < 72)
      return WeightW'($urandom_range(8, 1));
    return WeightW'($urandom_range(65535, 1));
  endfunction

  // One well-formed column: a few children, the last one closes it.
  task automatic send_random_column(inout int sent);
    int       kids;
    int       mode;
    in_item_t item;
    kids = ($urandom_range(9) == 0) ? $urandom_range(12, 5) : $urandom_range(4, 1);
    mode = $urandom_range(99);
    for (int k = 0; k < kids; k++) begin
      item = make_item(random_score(mode), random_score(mode), random_score(mode),
                       random_score(mode), $urandom_range(9) != 0, k == kids - 1,
                       random_weight(), $urandom_range(11) == 0);
      send_request(item);
      sent++;
    end
  endtask

  // Fully random fields, column end included.
  task automatic send_noise(inout int sent);
    send_request(make_item(score_t'($urandom()), score_t'($urandom()),
                           score_t'($urandom()), score_t'($urandom()),
                           1'($urandom_range(1)), 1'($urandom_range(1)),
                           WeightW'($urandom()), 1'($urandom_range(1))));
    sent++;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset cost rows: zero on the diagonal, one elsewhere.
  task automatic test_directed_columns();
    // empty column: all zero, unoccupied, total untouched
    send_request(make_item(ScoreMax, ScoreMax, ScoreMax, ScoreMax, 1'b0, 1'b1,
                           16'hFFFF, 1'b0));
    // lone child with zero scores
    send_request(make_item('0, '0, '0, '0, 1'b1, 1'b1, 16'd1, 1'b0));
    // alternating bit patterns, restart on a request that does not end the column
    send_request(make_item(24'hAAAAAA, 24'h555555, 24'h000000, ScoreMax, 1'b1, 1'b0,
                           16'h5555, 1'b1));
    // absent child mid column carries scores that must be ignored
    send_request(make_item(24'h000001, 24'h000002, 24'h000003, 24'h000004, 1'b0, 1'b0,
                           16'h0001, 1'b0));
    send_request(make_item(24'h555555, 24'hAAAAAA, ScoreMax, 24'h123456, 1'b1, 1'b1,
                           16'hAAAA, 1'b0));
    // two maximal children saturate the accumulator and the total; the column repeats
    repeat (2) begin
      send_request(make_item(ScoreMax, ScoreMax, ScoreMax, ScoreMax, 1'b1, 1'b0,
                             16'hFFFF, 1'b0));
      send_request(make_item(ScoreMax, ScoreMax, ScoreMax, ScoreMax, 1'b1, 1'b1,
                             16'hFFFF, 1'b0));
    end
    // restart on a column end: cleared first, then this column added
    send_request(make_item(24'd5, 24'd6, 24'd7, 24'd8, 1'b1, 1'b1, 16'd3, 1'b1));
    // zero weight adds nothing
    send_request(make_item(24'd9, 24'd1, 24'd3, 24'd4, 1'b1, 1'b1, 16'd0, 1'b0));
    // restart then an empty column: total reads zero
    send_request(make_item(24'd7, 24'd7, 24'd7, 24'd7, 1'b0, 1'b1, 16'd1, 1'b1));
  endtask

  // Cost matrix at its extremes and one uneven setting.
  task automatic test_cost_extremes();
    cost_rows_t rows;
    wait_idle();
    write_cost_rows('0);
    send_request(make_item(24'd40, 24'd10, 24'd30, 24'd20, 1'b1, 1'b0, 16'd1, 1'b0));
    send_request(make_item(24'd3, 24'd9, 24'd1, 24'd7, 1'b1, 1'b1, 16'd2, 1'b0));
    send_request(make_item(ScoreMax, ScoreMax, ScoreMax, ScoreMax, 1'b1, 1'b1,
                           16'd1, 1'b1));

    wait_idle();
    write_cost_rows({MaxLetters*CfgDataW{1'b1}});
    send_request(make_item(24'd0, 24'd1, 24'd2, 24'd3, 1'b1, 1'b0, 16'd1, 1'b1));
    send_request(make_item(ScoreMax, ScoreMax, ScoreMax, ScoreMax, 1'b1, 1'b1,
                           16'd7, 1'b0));

    wait_idle();
    rows[0] = 32'hFF80_0100;
    rows[1] = 32'h0001_7F02;
    rows[2] = 32'h40FE_0003;
    rows[3] = 32'h0010_20C0;
    write_cost_rows(rows);
    send_request(make_item(24'd100, 24'd0, 24'd50, 24'd255, 1'b1, 1'b0, 16'd1, 1'b0));
    send_request(make_item(24'd0, 24'd300, 24'd2, 24'd1, 1'b1, 1'b1, 16'd11, 1'b0));
  endtask

  // Mostly well-formed columns with random content, some noise. Each phase
  // runs with fresh cost rows; the second phase runs without sender gaps.
  task automatic test_random_traffic();
    int sent;
    int phase_end;
    sent = 0;
    for (int phase = 0; phase < RandomPhases; phase++) begin
      wait_idle();
      write_cost_rows(random_cost_rows(phase));
      sender_gaps_on = (phase != 1);
      phase_end = (RandomItems * (phase + 1)) / RandomPhases;
      while (sent < phase_end) begin
        if ($urandom_range(9) == 0)
          send_noise(sent);
        else
          send_random_column(sent);
      end
    end
    sender_gaps_on = 1'b1;
  endtask

  task automatic drain_results();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    while (pending_columns.size() != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    // catch anything extra the block still emits
    repeat (DrainCycles) @(posedge clk);
    if (pending_columns.size() != 0)
      report_mismatch($sformatf("%0d column results never arrived",
                                pending_columns.size()));
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    reset_predictor();
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_directed_columns();
    test_cost_extremes();
    test_random_traffic();
    drain_results();

    if (fail_count == 0) begin
      $display("sankoff_column_combine_top_tb passed");
    end else begin
      $display("sankoff_column_combine_top_tb failed");
    end
    $finish;
  end

  // Hang guard, several times the slowest legal run.
  initial begin
    #4_000_000;
    $display("sankoff_column_combine_top_tb failed");
    $finish;
  end

endmodule
